[src/cb64_pkg.sv]
// ----------------------------------------------------------------------------
// cb64_pkg
// Shared types, constants and the Base64 alphabet for the chunked encoder.
// ----------------------------------------------------------------------------
package cb64_pkg;

  localparam int unsigned CHUNK_SIZE_RESET    = 4096;
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

  localparam logic [7:0]  PAD_CHAR      = 8'h3D;
  localparam logic [15:0] CHUNK_NUM_MAX = 16'hFFFF;
  localparam logic [15:0] CHUNK_NUM_ONE = 16'd1;

  // Number of real bytes in a group.
  localparam logic [1:0] HAVE_ONE   = 2'd1;
  localparam logic [1:0] HAVE_TWO   = 2'd2;
  localparam logic [1:0] HAVE_THREE = 2'd3;

  // Character slot within a group.
  localparam logic [1:0] SLOT_FIRST = 2'd0;
  localparam logic [1:0] SLOT_LAST  = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       message_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_char;
    logic        run_last;
    logic        chunk_end;
    logic        message_end;
    logic [15:0] chunk_number;
  } out_item_t;

  // One group handed from the front to the back: left-aligned bytes,
  // real byte count and the marks for its last character.
  typedef struct packed {
    logic [23:0] block;
    logic [1:0]  have;
    logic        chunk_end;
    logic        message_end;
    logic [15:0] chunk_number;
  } group_job_t;

  // Standard Base64 alphabet.
  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage

[src/cb64_front.sv]
// ----------------------------------------------------------------------------
// cb64_front
// Takes raw bytes, tracks the pending group and chunk fill, and issues a
// group job whenever a group completes or a chunk or message ends.
// ----------------------------------------------------------------------------
module cb64_front
  import cb64_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [15:0] chunk_size,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       job_valid,
  input  logic       job_full,
  output group_job_t job
);

  logic [15:0] pending_bytes;
  logic [1:0]  pending_count;
  logic [15:0] chunk_fill;
  logic [15:0] current_chunk;

  logic [16:0] fill;
  logic [16:0] limit;
  logic        end_chunk;
  logic [23:0] block;
  logic        full_group;
  logic        accept;

  assign fill       = {1'b0, chunk_fill} + 17'd1;
  assign limit      = (chunk_size == 16'd0) ? 17'h10000 : {1'b0, chunk_size};
  assign end_chunk  = in_data.message_last || (fill >= limit);
  assign block      = {pending_bytes, in_data.data_byte};
  assign full_group = (pending_count == HAVE_TWO);

  assign in_stall = job_full;
  assign accept   = in_valid && !job_full;

  always_comb begin
    job.have         = pending_count + 2'd1;
    job.chunk_end    = end_chunk;
    job.message_end  = in_data.message_last;
    job.chunk_number = current_chunk;
    unique case (pending_count)
      2'd0:    job.block = {block[7:0], 16'h0000};
      2'd1:    job.block = {block[15:0], 8'h00};
      default: job.block = block;
    endcase
  end

  assign job_valid = accept && (full_group || end_chunk);

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bytes <= '0;
      pending_count <= '0;
      chunk_fill    <= '0;
      current_chunk <= CHUNK_NUM_ONE;
    end else if (accept) begin
      if (end_chunk || full_group) begin
        pending_bytes <= '0;
        pending_count <= '0;
      end else begin
        pending_bytes <= block[15:0];
        pending_count <= pending_count + 2'd1;
      end
      if (in_data.message_last) begin
        chunk_fill    <= '0;
        current_chunk <= CHUNK_NUM_ONE;
      end else if (end_chunk) begin
        chunk_fill <= '0;
        if (current_chunk != CHUNK_NUM_MAX) begin
          current_chunk <= current_chunk + 16'd1;
        end
      end else begin
        chunk_fill <= fill[15:0];
      end
    end
  end

endmodule

[src/cb64_queue.sv]
// ----------------------------------------------------------------------------
// cb64_queue
// Small register FIFO of group jobs between the front and the back.
// ----------------------------------------------------------------------------
module cb64_queue
  import cb64_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  group_job_t push_job,
  output logic       full,
  input  logic       pop,
  output logic       head_valid,
  output group_job_t head_job
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  group_job_t       entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == FULL_CNT);
  assign head_valid = (count != '0);
  assign head_job   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

[src/cb64_back.sv]
// ----------------------------------------------------------------------------
// cb64_back
// Expands each group job into four characters, one per cycle while the output
// is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module cb64_back
  import cb64_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  group_job_t head_job,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data
);

  logic [1:0] slot;
  logic       load;
  logic [5:0] sextet;
  logic       pad;
  out_item_t  next_item;

  assign load = head_valid && (!out_valid || !out_stall);
  assign pop  = load && (slot == SLOT_LAST);

  always_comb begin
    unique case (slot)
      2'd0: begin
        sextet = head_job.block[23:18];
        pad    = 1'b0;
      end
      2'd1: begin
        sextet = head_job.block[17:12];
        pad    = 1'b0;
      end
      2'd2: begin
        sextet = head_job.block[11:6];
        pad    = (head_job.have == HAVE_ONE);
      end
      default: begin
        sextet = head_job.block[5:0];
        pad    = (head_job.have != HAVE_THREE);
      end
    endcase
    next_item.out_char     = pad ? PAD_CHAR : b64_char(sextet);
    next_item.run_last     = (slot == SLOT_LAST);
    next_item.chunk_end    = (slot == SLOT_LAST) && head_job.chunk_end;
    next_item.message_end  = (slot == SLOT_LAST) && head_job.message_end;
    next_item.chunk_number = head_job.chunk_number;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= next_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      slot      <= SLOT_FIRST;
    end else if (load) begin
      out_valid <= 1'b1;
      slot      <= slot + 2'd1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

[src/chunked_base64_encoder_core.sv]
// ----------------------------------------------------------------------------
// chunked_base64_encoder_core
// Byte-serial Base64 encoder that restarts padding in every chunk.
// ----------------------------------------------------------------------------
// The encoder takes one message byte per request and splits the message into
// chunks of chunk_size bytes (zero means 65536), encoding each chunk as an
// independent Base64 string with the standard alphabet. Bytes are accepted at
// up to one per cycle while the group queue has room; characters leave at one
// per cycle while the output is not stalled, and each group yields four
// characters. With a chunk size of one every byte flushes a padded group.
// The back end emits through a single-character output register, which
// limits the throughput. Each character carries the chunk number it belongs
// to (one-based, saturating at 65535); the last character of each group has
// run_last set, plus chunk_end and message_end when the group closes a chunk
// or the message. The chunk size should only be written while no encoding is
// in flight.
// ----------------------------------------------------------------------------
module chunked_base64_encoder_core
  import cb64_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // Chunk size register write port.
  input  logic        cfg_write,
  input  logic [15:0] cfg_data,
  // Byte requests.
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  // Character requests.
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data
);

  logic [15:0] chunk_size;

  // The front classifies each byte and emits a job when a group completes
  // or a chunk or the message ends.
  logic       job_valid;
  logic       job_full;
  group_job_t job;

  // The queue lets the front keep accepting bytes while the back is still
  // draining characters of earlier groups.
  logic       head_valid;
  logic       pop;
  group_job_t head_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_size <= 16'(CHUNK_SIZE_RESET);
    end else if (cfg_write) begin
      chunk_size <= cfg_data;
    end
  end

  cb64_front u_front (
    .clk        (clk),
    .rst        (rst),
    .chunk_size (chunk_size),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .job_valid  (job_valid),
    .job_full   (job_full),
    .job        (job)
  );

  cb64_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (job_valid),
    .push_job   (job),
    .full       (job_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // The back expands each job into four characters through its output
  // register, so a waiting character never blocks the input side directly.
  cb64_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
